[rtl/core/des_pkg.sv]
// ----------------------------------------------------------------------------
// des_pkg
// shared types, register indexes and level codes for the dual elevator
// step sequencer
// ----------------------------------------------------------------------------
package des_pkg;

    localparam int DES_POS_WIDTH = 16;   // default width of the remaining-steps counters
    localparam int CFG_W         = 15;   // width of every configuration field
    localparam int STEP_W        = 16;   // width of a signed step chunk
    localparam int LVL_W         = 2;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;
    localparam int REG_IDX_W     = 3;

    // level codes
    localparam logic [LVL_W-1:0] LVL_DOWN   = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MIDDLE = 2'd1;
    localparam logic [LVL_W-1:0] LVL_UP     = 2'd2;
    localparam logic [LVL_W-1:0] LVL_BAD    = 2'd3;

    // register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_MIDDLE_POS_A = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_UP_POS_A     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIDDLE_POS_B = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_UP_POS_B     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CHUNK_MAX_A  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CHUNK_MAX_B  = 3'd5;

    typedef struct packed {
        logic             order_valid_a;
        logic [LVL_W-1:0] order_level_a;
        logic             order_valid_b;
        logic [LVL_W-1:0] order_level_b;
    } t_in_item;

    typedef struct packed {
        logic signed [STEP_W-1:0] steps_a;
        logic signed [STEP_W-1:0] steps_b;
        logic                     reply_a;
        logic                     reply_b;
        logic                     done_a;
        logic                     done_b;
        logic [LVL_W-1:0]         level_out_a;
        logic [LVL_W-1:0]         level_out_b;
    } t_out_item;

    // per-elevator configuration
    typedef struct packed {
        logic [CFG_W-1:0] mid_pos;
        logic [CFG_W-1:0] up_pos;
        logic [CFG_W-1:0] chunk;
    } t_lift_cfg;

    // per-elevator result of one tick
    typedef struct packed {
        logic signed [STEP_W-1:0] steps;
        logic                     reply;
        logic                     done;
        logic [LVL_W-1:0]         level;
    } t_lift_res;

endpackage

[rtl/core/dual_elevator_step_sequencer_core.sv]
// ----------------------------------------------------------------------------
// dual_elevator_step_sequencer_core
// step sequencer for two stacked elevators, lower (a) and upper (b), with an
// apb register file for level positions and per-tick chunk limits
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  in        input      i_in_valid/o_in_ready   i_in_data  (t_in_item)
//  out       output     o_out_valid/i_out_ready o_out_data (t_out_item)
//  apb       input      psel/penable/pready     paddr, pwdata, prdata
//
//  one control tick per cycle sustained while results are taken; a tick
//  passes the input register, then the result register, before its
//  result can transfer
//  both lifts evaluate in one combinational pass between the two registers
//  a stalled result holds in the result register while the input register
//  still takes one more tick
//  synchronous active-low reset: both lifts down, nothing pending,
//  positions zero and chunk limits one
// ----------------------------------------------------------------------------
module dual_elevator_step_sequencer_core
    import des_pkg::*;
#(
    parameter int POS_WIDTH = DES_POS_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // control ticks
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    // per-tick results
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // input register
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in, n_in;
    // result register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic      adv;        // tick moves from input register to result register
    logic      in_xfer;

    t_lift_cfg        cfg_a, cfg_b;
    t_lift_res        res_a, res_b;
    logic [LVL_W-1:0] level_a, level_b;
    logic             blocked_a, blocked_b;
    logic             order_en_a, order_en_b;

    des_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg_a (cfg_a),
        .o_cfg_b (cfg_b)
    );

    // handshake and register advance
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign in_xfer    = i_in_valid && o_in_ready;

    // a may not rise above b's current level
    assign blocked_a  = (r_in.order_level_a > level_b);
    assign order_en_a = r_in.order_valid_a && !blocked_a;

    // b may not sink below a's level as just updated by this tick
    assign blocked_b  = (r_in.order_level_b < res_a.level);
    assign order_en_b = r_in.order_valid_b && !blocked_b;

    des_lift #(.POS_WIDTH(POS_WIDTH)) u_lift_a (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_cfg         (cfg_a),
        .i_order_en    (order_en_a),
        .i_order_level (r_in.order_level_a),
        .o_level       (level_a),
        .o_res         (res_a)
    );

    des_lift #(.POS_WIDTH(POS_WIDTH)) u_lift_b (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_cfg         (cfg_b),
        .i_order_en    (order_en_b),
        .i_order_level (r_in.order_level_b),
        .o_level       (level_b),
        .o_res         (res_b)
    );

    always_comb begin
        n_in_valid  = in_xfer || (r_in_valid && !adv);
        n_in        = in_xfer ? i_in_data : r_in;
        n_out_valid = adv || (r_out_valid && !i_out_ready);
        n_out       = r_out;
        if (adv) begin
            n_out.steps_a     = res_a.steps;
            n_out.steps_b     = res_b.steps;
            // refused by the other lift, or invalid / redundant here
            n_out.reply_a     = r_in.order_valid_a && (blocked_a || res_a.reply);
            n_out.reply_b     = r_in.order_valid_b && (blocked_b || res_b.reply);
            n_out.done_a      = res_a.done;
            n_out.done_b      = res_b.done;
            n_out.level_out_a = res_a.level;
            n_out.level_out_b = res_b.level;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // stacking order is never violated
    a_stack_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level_a <= level_b)
        else $error("lower lift above upper lift");

    // no invalid level is ever stored
    a_level_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (level_a != LVL_BAD) && (level_b != LVL_BAD))
        else $error("invalid level stored");

    // the final chunk always moves the lift
    a_done_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && (res_a.done || res_b.done) |->
            (!res_a.done || (res_a.steps != '0)) && (!res_b.done || (res_b.steps != '0)))
        else $error("done raised on an empty chunk");

    // a tick held back by a stalled result is not dropped
    a_tick_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("held tick lost");

endmodule

[rtl/core/des_regs.sv]
// ----------------------------------------------------------------------------
// des_regs
// apb register file: level positions and chunk limits of both elevators
// ----------------------------------------------------------------------------
module des_regs
    import des_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_lift_cfg         o_cfg_a,
    output t_lift_cfg         o_cfg_b
);

    logic [CFG_W-1:0]     r_mid_a, r_up_a, r_mid_b, r_up_b, r_chunk_a, r_chunk_b;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [CFG_W-1:0]     wr_val;
    logic [CFG_W-1:0]     rd_val;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign wr_val  = pwdata[CFG_W-1:0];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_a   <= '0;
            r_up_a    <= '0;
            r_mid_b   <= '0;
            r_up_b    <= '0;
            r_chunk_a <= CFG_W'(1);
            r_chunk_b <= CFG_W'(1);
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIDDLE_POS_A: r_mid_a   <= wr_val;
                REG_UP_POS_A:     r_up_a    <= wr_val;
                REG_MIDDLE_POS_B: r_mid_b   <= wr_val;
                REG_UP_POS_B:     r_up_b    <= wr_val;
                REG_CHUNK_MAX_A:  r_chunk_a <= wr_val;
                REG_CHUNK_MAX_B:  r_chunk_b <= wr_val;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIDDLE_POS_A: rd_val = r_mid_a;
            REG_UP_POS_A:     rd_val = r_up_a;
            REG_MIDDLE_POS_B: rd_val = r_mid_b;
            REG_UP_POS_B:     rd_val = r_up_b;
            REG_CHUNK_MAX_A:  rd_val = r_chunk_a;
            REG_CHUNK_MAX_B:  rd_val = r_chunk_b;
            default:          rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DW-CFG_W){1'b0}}, rd_val};

    assign o_cfg_a = '{mid_pos: r_mid_a, up_pos: r_up_a, chunk: r_chunk_a};
    assign o_cfg_b = '{mid_pos: r_mid_b, up_pos: r_up_b, chunk: r_chunk_b};

endmodule

[rtl/core/des_lift.sv]
// ----------------------------------------------------------------------------
// des_lift
// one elevator: level and remaining-steps state, order handling and
// per-tick chunk emission
// ----------------------------------------------------------------------------
module des_lift
    import des_pkg::*;
#(
    parameter int POS_WIDTH = DES_POS_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,          // commit this tick
    input  t_lift_cfg        i_cfg,
    input  logic             i_order_en,     // order present and not blocked by the other lift
    input  logic [LVL_W-1:0] i_order_level,
    output logic [LVL_W-1:0] o_level,        // registered level
    output t_lift_res        o_res
);

    localparam int CW = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 2;
    localparam longint LIM_L = (longint'(1) << (POS_WIDTH - 1)) - longint'(1);
    localparam logic signed [CW-1:0] PEND_LIM = CW'(LIM_L);

    logic [LVL_W-1:0]            r_level, n_level;
    logic signed [POS_WIDTH-1:0] r_pending, n_pending;

    logic [CFG_W-1:0]     cur_pos, tgt_pos, chunk_m;
    logic                 lvl_same, at_rest, take;
    logic signed [CW-1:0] pend_ext, diff, diff_sat, pend_mid, m_ext, step_ext, pend_new;
    logic                 done;

    function automatic logic [CFG_W-1:0] pos_of(input t_lift_cfg cfg,
                                                 input logic [LVL_W-1:0] lvl);
        logic [CFG_W-1:0] p;
        case (lvl)
            LVL_UP:     p = cfg.up_pos;
            LVL_MIDDLE: p = cfg.mid_pos;
            default:    p = '0;
        endcase
        return p;
    endfunction

    always_comb begin
        cur_pos  = pos_of(i_cfg, r_level);
        tgt_pos  = pos_of(i_cfg, i_order_level);
        lvl_same = (i_order_level == r_level);
        at_rest  = (r_pending == '0);
        take     = i_order_en && !lvl_same && (i_order_level != LVL_BAD);

        // new remaining = target - (current position - remaining)
        pend_ext = {{(CW-POS_WIDTH){r_pending[POS_WIDTH-1]}}, r_pending};
        diff     = $signed({{(CW-CFG_W){1'b0}}, tgt_pos})
                 - $signed({{(CW-CFG_W){1'b0}}, cur_pos}) + pend_ext;
        if (diff > PEND_LIM) begin
            diff_sat = PEND_LIM;
        end else if (diff < -PEND_LIM) begin
            diff_sat = -PEND_LIM;
        end else begin
            diff_sat = diff;
        end
        pend_mid = take ? diff_sat : pend_ext;
        n_level  = take ? i_order_level : r_level;

        // chunk limit of zero acts as one
        chunk_m = (i_cfg.chunk == '0) ? CFG_W'(1) : i_cfg.chunk;
        m_ext   = $signed({{(CW-CFG_W){1'b0}}, chunk_m});
        done    = 1'b0;
        if (pend_mid < -m_ext) begin
            step_ext = -m_ext;
            pend_new = pend_mid + m_ext;
        end else if (pend_mid > m_ext) begin
            step_ext = m_ext;
            pend_new = pend_mid - m_ext;
        end else begin
            step_ext = pend_mid;
            pend_new = '0;
            done     = (pend_mid != '0);
        end
        n_pending = pend_new[POS_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LVL_DOWN;
            r_pending <= '0;
        end else if (i_adv) begin
            r_level   <= n_level;
            r_pending <= n_pending;
        end
    end

    assign o_level     = r_level;
    assign o_res.steps = step_ext[STEP_W-1:0];
    assign o_res.reply = i_order_en && ((lvl_same && at_rest) ||
                                        (!lvl_same && (i_order_level == LVL_BAD)));
    assign o_res.done  = done;
    assign o_res.level = n_level;

endmodule

[test/tb_dual_elevator_step_sequencer_core.sv]
// ----------------------------------------------------------------------------
// tb_dual_elevator_step_sequencer_core
// self-checking bench for the dual elevator step sequencer: control ticks go
// in over a valid/ready channel and per-tick results are checked field by
// field against a cycle-free model of both lifts kept inside the bench,
// while the apb port walks the level positions and chunk limits through
// several settings, extremes included
// ----------------------------------------------------------------------------
module tb_dual_elevator_step_sequencer_core
    import des_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD        = 10;
    localparam int RESET_CYCLES      = 6;
    localparam int HOLD_CYCLES       = 300;   // long receiver hold-off
    localparam int STALL_LIMIT       = 2000;  // cycles with no transfer at all
    localparam int SETTINGS_PER_MODE = 4;
    localparam int TICKS_PER_SETTING = 100;
    localparam int MAX_REPORTS       = 100;
    localparam int SETTLE_CYCLES     = 8;     // two-stage pipeline plus margin
    // remaining-steps counters saturate at this magnitude
    localparam int PEND_LIM          = (1 << (DES_POS_WIDTH - 1)) - 1;

    // model of one lift: its registers plus level and remaining steps
    typedef struct {
        logic [CFG_W-1:0] mid_pos;
        logic [CFG_W-1:0] up_pos;
        logic [CFG_W-1:0] chunk;
        logic [LVL_W-1:0] level;
        int               pending;
    } t_lift_state;

    // ------------------------------------------------------------------------
    // clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_in_item          i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_out_item         o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [APB_AW-1:0] paddr       = '0;
    logic [APB_DW-1:0] pwdata      = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    dual_elevator_step_sequencer_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // bench state
    // ------------------------------------------------------------------------
    t_lift_state lift_lo;          // elevator a, the lower one
    t_lift_state lift_hi;          // elevator b, the upper one
    t_out_item   tick_results_q[$];

    int send_idle_pct = 0;         // chance in a hundred that the sender idles
    int recv_idle_pct = 0;         // chance in a hundred that the receiver stalls
    int hold_gen      = 0;         // bumped by the pressure test only
    int hold_seen     = 0;
    int hold_left     = 0;
    int stall_cycles  = 0;

    int n_errors  = 0;
    int n_ticks   = 0;
    int n_results = 0;
    int n_writes  = 0;
    int n_done    = 0;
    int n_reply   = 0;

    // ------------------------------------------------------------------------
    // lift model
    // ------------------------------------------------------------------------
    function automatic int level_position(t_lift_state l, logic [LVL_W-1:0] lvl);
        if (lvl == LVL_UP)
            return int'(l.up_pos);
        if (lvl == LVL_MIDDLE)
            return int'(l.mid_pos);
        return 0;
    endfunction

    // returns 1 when the order is taken without a reply
    function automatic bit take_order(inout t_lift_state l, input logic [LVL_W-1:0] lvl);
        int here;
        int travel;
        // redundant: already there and at rest
        if (lvl == l.level && l.pending == 0)
            return 1'b0;
        // same level while still moving is taken silently, nothing changes
        if (lvl != l.level) begin
            if (lvl == LVL_BAD)
                return 1'b0;
            here   = level_position(l, l.level) - l.pending;
            travel = level_position(l, lvl) - here;
            // positions may have moved under a running lift
            if (travel > PEND_LIM)
                travel = PEND_LIM;
            else if (travel < -PEND_LIM)
                travel = -PEND_LIM;
            l.pending = travel;
            l.level   = lvl;
        end
        return 1'b1;
    endfunction

    // one chunk per tick; returns 1 on the final chunk of a move
    function automatic bit emit_chunk(inout t_lift_state l,
                                      output logic signed [STEP_W-1:0] steps);
        int lim;
        lim   = (l.chunk == '0) ? 1 : int'(l.chunk);   // a zero limit acts as one
        steps = '0;
        if (l.pending < -lim) begin
            steps     = STEP_W'(-lim);
            l.pending = l.pending + lim;
        end else if (l.pending > lim) begin
            steps     = STEP_W'(lim);
            l.pending = l.pending - lim;
        end else if (l.pending != 0) begin
            steps     = STEP_W'(l.pending);
            l.pending = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // order a is settled first, so b is judged against a's new level
    function automatic t_out_item predict_tick(t_in_item it);
        t_out_item                r;
        logic signed [STEP_W-1:0] sa;
        logic signed [STEP_W-1:0] sb;
        r = '0;
        if (it.order_valid_a) begin
            if (it.order_level_a > lift_hi.level)
                r.reply_a = 1'b1;
            else if (!take_order(lift_lo, it.order_level_a))
                r.reply_a = 1'b1;
        end
        if (it.order_valid_b) begin
            if (it.order_level_b < lift_lo.level)
                r.reply_b = 1'b1;
            else if (!take_order(lift_hi, it.order_level_b))
                r.reply_b = 1'b1;
        end
        r.done_a      = emit_chunk(lift_lo, sa);
        r.done_b      = emit_chunk(lift_hi, sb);
        r.steps_a     = sa;
        r.steps_b     = sb;
        r.level_out_a = lift_lo.level;
        r.level_out_b = lift_hi.level;
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] cfg_mirror(logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_MIDDLE_POS_A: return lift_lo.mid_pos;
            REG_UP_POS_A:     return lift_lo.up_pos;
            REG_MIDDLE_POS_B: return lift_hi.mid_pos;
            REG_UP_POS_B:     return lift_hi.up_pos;
            REG_CHUNK_MAX_A:  return lift_lo.chunk;
            REG_CHUNK_MAX_B:  return lift_hi.chunk;
            default:          return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_tick(logic va, logic [LVL_W-1:0] la,
                                           logic vb, logic [LVL_W-1:0] lb);
        t_in_item it;
        it.order_valid_a = va;
        it.order_level_a = la;
        it.order_valid_b = vb;
        it.order_level_b = lb;
        return it;
    endfunction

    // mostly proper levels; invalid codes now and then
    function automatic t_in_item random_tick();
        t_in_item it;
        it.order_valid_a = ($urandom_range(99) < 35);
        it.order_level_a = ($urandom_range(99) < 8) ? LVL_BAD : LVL_W'($urandom_range(2));
        it.order_valid_b = ($urandom_range(99) < 35);
        it.order_level_b = ($urandom_range(99) < 8) ? LVL_BAD : LVL_W'($urandom_range(2));
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] random_position();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_chunk();
        case ($urandom_range(19))
            0:       return '0;
            1, 2:    return '1;
            3, 4:    return CFG_W'(1);
            default: return CFG_W'($urandom_range(2, 400));
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        if (n_errors < MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
        n_errors++;
    endtask

    task automatic compare_tick(input t_out_item got, input t_out_item want);
        string diff;
        diff = "";
        if (got.steps_a !== want.steps_a)
            diff = {diff, $sformatf(" steps_a %0d/%0d", got.steps_a, want.steps_a)};
        if (got.steps_b !== want.steps_b)
            diff = {diff, $sformatf(" steps_b %0d/%0d", got.steps_b, want.steps_b)};
        if (got.reply_a !== want.reply_a)
            diff = {diff, $sformatf(" reply_a %b/%b", got.reply_a, want.reply_a)};
        if (got.reply_b !== want.reply_b)
            diff = {diff, $sformatf(" reply_b %b/%b", got.reply_b, want.reply_b)};
        if (got.done_a !== want.done_a)
            diff = {diff, $sformatf(" done_a %b/%b", got.done_a, want.done_a)};
        if (got.done_b !== want.done_b)
            diff = {diff, $sformatf(" done_b %b/%b", got.done_b, want.done_b)};
        if (got.level_out_a !== want.level_out_a)
            diff = {diff, $sformatf(" level_out_a %0d/%0d", got.level_out_a, want.level_out_a)};
        if (got.level_out_b !== want.level_out_b)
            diff = {diff, $sformatf(" level_out_b %0d/%0d", got.level_out_b, want.level_out_b)};
        if (diff != "")
            report_mismatch($sformatf("result %0d (got/expected):%s", n_results, diff));
    endtask

    // one control tick: optional idle gap, then hold valid until the transfer;
    // valid is left high so a following tick can go out back to back
    task automatic send_tick(input t_in_item it);
        t_out_item want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        want = predict_tick(it);
        tick_results_q.push_back(want);
        n_ticks++;
        n_done  += want.done_a + want.done_b;
        n_reply += want.reply_a + want.reply_b;
    endtask

    // stop offering ticks and wait for every outstanding result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tick_results_q.size() != 0);
    endtask

    // one apb transfer; psel and penable are left high so transfers can run
    // back to back, apb_idle closes a burst
    task automatic apb_xfer(input bit wr, input logic [REG_IDX_W-1:0] idx,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_check(input logic [REG_IDX_W-1:0] idx);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b0, idx, $urandom, rd);
        if (rd[CFG_W-1:0] !== cfg_mirror(idx))
            report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                      idx, rd[CFG_W-1:0], cfg_mirror(idx)));
    endtask

    // write with random upper data bits, then read back
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        logic [APB_DW-1:0] wd;
        logic [APB_DW-1:0] rd;
        wd            = $urandom;
        wd[CFG_W-1:0] = value;
        apb_xfer(1'b1, idx, wd, rd);
        case (idx)
            REG_MIDDLE_POS_A: lift_lo.mid_pos = value;
            REG_UP_POS_A:     lift_lo.up_pos  = value;
            REG_MIDDLE_POS_B: lift_hi.mid_pos = value;
            REG_UP_POS_B:     lift_hi.up_pos  = value;
            REG_CHUNK_MAX_A:  lift_lo.chunk   = value;
            REG_CHUNK_MAX_B:  lift_hi.chunk   = value;
            default: ;
        endcase
        n_writes++;
        cfg_check(idx);
    endtask

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // reset register values, then a few orders with every position at zero
    task automatic test_reset_state();
        for (int i = 0; i < 6; i++)
            cfg_check(REG_IDX_W'(i));
        apb_idle();
        send_tick(make_tick(1'b0, LVL_DOWN, 1'b1, LVL_UP));     // b up, nothing to travel
        send_tick(make_tick(1'b1, LVL_UP, 1'b0, LVL_DOWN));     // a up under b
        send_tick(make_tick(1'b0, LVL_UP, 1'b1, LVL_MIDDLE));   // b below a, refused
        drain_results();
    endtask

    // every order outcome with modest positions and chunk limits
    task automatic test_order_rules();
        cfg_write(REG_MIDDLE_POS_A, CFG_W'(100));
        cfg_write(REG_UP_POS_A,     CFG_W'(250));
        cfg_write(REG_MIDDLE_POS_B, CFG_W'(120));
        cfg_write(REG_UP_POS_B,     CFG_W'(300));
        cfg_write(REG_CHUNK_MAX_A,  CFG_W'(40));
        cfg_write(REG_CHUNK_MAX_B,  CFG_W'(64));
        apb_idle();
        // a starts down; b gets an invalid level
        send_tick(make_tick(1'b1, LVL_DOWN, 1'b1, LVL_BAD));
        // same level while still moving: taken silently
        send_tick(make_tick(1'b1, LVL_DOWN, 1'b0, LVL_UP));
        // invalid for a, redundant for b at rest
        send_tick(make_tick(1'b1, LVL_BAD, 1'b1, LVL_UP));
        // a reverses upward, b may not go below it
        send_tick(make_tick(1'b1, LVL_UP, 1'b1, LVL_DOWN));
        send_tick(make_tick(1'b0, LVL_UP, 1'b0, LVL_UP));
        // both lifts ordered in one tick
        send_tick(make_tick(1'b1, LVL_MIDDLE, 1'b1, LVL_MIDDLE));
        // a above b, refused while motion goes on
        send_tick(make_tick(1'b1, LVL_UP, 1'b0, LVL_DOWN));
        // a drops first, so b may follow it down in the same tick
        send_tick(make_tick(1'b1, LVL_DOWN, 1'b1, LVL_DOWN));
        // invalid orders while the moves finish: reply and done together
        repeat (5) send_tick(make_tick(1'b1, LVL_BAD, 1'b1, LVL_BAD));
        drain_results();
    endtask

    // chunk limits of zero and full scale, and remaining steps pushed past
    // the counter range by moving positions under a running lift
    task automatic test_limits();
        cfg_write(REG_MIDDLE_POS_A, CFG_W'(3));
        cfg_write(REG_UP_POS_A,     '1);
        cfg_write(REG_MIDDLE_POS_B, '0);
        cfg_write(REG_UP_POS_B,     '1);
        cfg_write(REG_CHUNK_MAX_A,  '0);
        cfg_write(REG_CHUNK_MAX_B,  '1);
        apb_idle();
        send_tick(make_tick(1'b0, LVL_DOWN, 1'b1, LVL_UP));     // whole move in one chunk
        send_tick(make_tick(1'b1, LVL_MIDDLE, 1'b0, LVL_DOWN)); // single steps
        repeat (2) send_tick(make_tick(1'b0, LVL_DOWN, 1'b0, LVL_DOWN));
        send_tick(make_tick(1'b1, LVL_UP, 1'b0, LVL_DOWN));     // long climb for a
        drain_results();
        // up position collapses while a climbs: next order overshoots upward
        cfg_write(REG_UP_POS_A,     '0);
        cfg_write(REG_MIDDLE_POS_A, '1);
        apb_idle();
        send_tick(make_tick(1'b1, LVL_MIDDLE, 1'b0, LVL_DOWN));
        drain_results();
        cfg_write(REG_CHUNK_MAX_A, '1);
        cfg_write(REG_CHUNK_MAX_B, CFG_W'(1));
        apb_idle();
        send_tick(make_tick(1'b1, LVL_DOWN, 1'b1, LVL_MIDDLE)); // b starts full scale down
        drain_results();
        // middle position jumps while b descends: overshoot downward
        cfg_write(REG_MIDDLE_POS_B, '1);
        apb_idle();
        send_tick(make_tick(1'b0, LVL_DOWN, 1'b1, LVL_DOWN));
        drain_results();
        cfg_write(REG_CHUNK_MAX_B, '1);
        apb_idle();
        send_tick(make_tick(1'b0, LVL_DOWN, 1'b0, LVL_DOWN));
        drain_results();
    endtask

    // receiver holds off for a long stretch while ticks keep coming, so both
    // pipeline stages fill and the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_gen++;
        repeat (40) send_tick(random_tick());
        drain_results();
    endtask

    task automatic test_random_mode(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int s = 0; s < SETTINGS_PER_MODE; s++) begin
            drain_results();
            cfg_write(REG_MIDDLE_POS_A, random_position());
            cfg_write(REG_UP_POS_A,     random_position());
            cfg_write(REG_MIDDLE_POS_B, random_position());
            cfg_write(REG_UP_POS_B,     random_position());
            cfg_write(REG_CHUNK_MAX_A,  random_chunk());
            cfg_write(REG_CHUNK_MAX_B,  random_chunk());
            apb_idle();
            repeat (TICKS_PER_SETTING) send_tick(random_tick());
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // receiver: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_results_q.size() == 0) begin
                report_mismatch("result transfer with no tick outstanding");
            end else begin
                compare_tick(o_out_data, tick_results_q.pop_front());
                n_results++;
            end
        end
    end

    // watchdog: too long without any transfer on any port ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (psel && penable && pready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        lift_lo = '{mid_pos: '0, up_pos: '0, chunk: CFG_W'(1), level: LVL_DOWN, pending: 0};
        lift_hi = lift_lo;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part runs with a lazy receiver
        send_idle_pct = 23;
        recv_idle_pct = 68;
        test_reset_state();
        test_order_rules();
        test_limits();
        test_backpressure();

        test_random_mode(23, 68);
        test_random_mode(68, 23);
        test_random_mode(0, 0);

        // let anything stray surface before the verdict
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tick_results_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", tick_results_q.size()));

        $display("summary: %0d control ticks, %0d results checked, %0d register writes",
                 n_ticks, n_results, n_writes);
        $display("summary: %0d finished moves and %0d answered orders seen, %0d mismatches",
                 n_done, n_reply, n_errors);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
